### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### hw/rtl/u8d_pkg.sv
// types, constants and the sequence decode function of the utf-8 decoder
package u8d_pkg;

    localparam int BUF_BYTES = 4;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] MIN_CP2     = 21'h000080;
    localparam logic [20:0] MIN_CP3     = 21'h000800;
    localparam logic [20:0] MIN_CP4     = 21'h010000;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    typedef logic [BUF_BYTES-1:0][7:0] t_buf;

    // outcome of decoding at one byte position
    typedef struct packed {
        logic        hold;   // open sequence, needs more bytes
        logic        sub;
        logic [2:0]  len;
        logic [20:0] cp;
    } t_dec;

    // what the scanner hands back to the top level
    typedef struct packed {
        logic        busy;   // a result is ready at the head of the buffer
        logic        more;   // another result follows in this request
        logic        sub;
        logic [2:0]  len;
        logic [20:0] cp;
    } t_scan;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    // decode the sequence starting at the low byte of bytes, avail bytes present
    function automatic t_dec decode_seq(input logic [31:0] bytes,
                                        input logic [2:0]  avail,
                                        input logic        eot);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  len;
        logic        ascii;
        logic        bad;
        logic        short_seq;
        logic        out_of_range;
        logic [20:0] cp;
        t_dec        d;
        b0 = bytes[7:0];
        b1 = bytes[15:8];
        b2 = bytes[23:16];
        b3 = bytes[31:24];
        ascii = !b0[7];
        bad = 1'b0;
        len = 3'd1;
        if (ascii) begin
            len = 3'd1;
        end else if ((b0 & LEAD2_MASK) == LEAD2_CODE) begin
            len = 3'd2;
        end else if ((b0 & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3'd3;
        end else if ((b0 & LEAD4_MASK) == LEAD4_CODE) begin
            len = 3'd4;
        end else begin
            bad = 1'b1;
        end
        // any non-continuation inside the available part settles the lead as bad
        if (len >= 3'd2 && avail >= 3'd2 && !is_cont(b1)) bad = 1'b1;
        if (len >= 3'd3 && avail >= 3'd3 && !is_cont(b2)) bad = 1'b1;
        if (len >= 3'd4 && avail >= 3'd4 && !is_cont(b3)) bad = 1'b1;
        short_seq = avail < len;
        case (len)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
        out_of_range = (len == 3'd2 && cp < MIN_CP2) ||
                       (len == 3'd3 && cp < MIN_CP3) ||
                       (len == 3'd4 && cp < MIN_CP4) ||
                       (cp >= SURR_LO && cp <= SURR_HI) ||
                       (cp > MAX_CP);
        d.hold = 1'b0;
        d.sub  = 1'b0;
        d.len  = len;
        d.cp   = cp;
        if (ascii) begin
            d.len = 3'd1;
        end else if (bad || (short_seq && eot) || (!short_seq && out_of_range)) begin
            d.sub = 1'b1;
            d.len = 3'd1;
            d.cp  = REPLACEMENT;
        end else if (short_seq) begin
            d.hold = 1'b1;
        end
        return d;
    endfunction

endpackage

### hw/rtl/u8d_scan.sv
// decodes the head of the byte buffer and looks ahead at the position after it
module u8d_scan (
    input  u8d_pkg::t_buf  i_buf,
    input  logic [2:0]     i_cnt,
    input  logic           i_eot,
    output u8d_pkg::t_scan o_scan
);

    u8d_pkg::t_dec dec [u8d_pkg::BUF_BYTES];

    // one decoder per start position
    always_comb begin
        for (int k = 0; k < u8d_pkg::BUF_BYTES; k++) begin
            dec[k] = u8d_pkg::decode_seq(32'(i_buf >> (8 * k)),
                                         (i_cnt > 3'(k)) ? i_cnt - 3'(k) : 3'd0,
                                         i_eot);
        end
    end

    always_comb begin
        o_scan.busy = (i_cnt != 3'd0) && !dec[0].hold;
        o_scan.sub  = dec[0].sub;
        o_scan.len  = dec[0].len;
        o_scan.cp   = dec[0].cp;
        o_scan.more = o_scan.busy && (i_cnt > dec[0].len) && !dec[dec[0].len[1:0]].hold;
    end

endmodule

### hw/rtl/utf8_decode_with_replacement_top.sv
// top level of the utf-8 decoder with replacement character
//
// Takes one byte per request and returns decoded code points, U+FFFD for each
// byte that breaks the encoding rules. A byte is taken every cycle while the
// output is not stalled and the byte yields at most one result; a byte that
// yields k results (held bytes being resolved by an error or by end of text)
// occupies the decode slot until its last result goes, as only the decoder at
// the buffer head releases results, one per cycle into the output register while it is free.
// A completing byte is registered in the four-byte buffer, then its result
// in the output register; held bytes give no result until the sequence resolves.
module utf8_decode_with_replacement_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic        o_is_substituted,
    output logic [2:0]  o_source_bytes,
    output logic        o_run_last,
    output logic        o_text_last
);

    u8d_pkg::t_buf  r_buf, n_buf;
    logic [2:0]     r_cnt, n_cnt;
    logic           r_eot, n_eot;
    u8d_pkg::t_scan scan;

    logic           out_free;
    logic           emit;
    logic           accept;
    logic [2:0]     base;

    u8d_scan u_scan (
        .i_buf  (r_buf),
        .i_cnt  (r_cnt),
        .i_eot  (r_eot),
        .o_scan (scan)
    );

    assign out_free   = !o_out_valid || i_out_ready;
    assign emit       = scan.busy && out_free;
    assign o_in_ready = !scan.busy || (out_free && !scan.more);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_eot = r_eot;
        base  = r_cnt;
        if (emit) begin
            n_buf = u8d_pkg::t_buf'(r_buf >> {scan.len, 3'b000});
            base  = r_cnt - scan.len;
            n_cnt = base;
        end
        // new byte goes behind whatever is still held
        if (accept) begin
            n_buf[base[1:0]] = i_byte_in;
            n_cnt = base + 3'd1;
            n_eot = i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= 3'd0;
            r_eot <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
            r_eot <= n_eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_code_point     <= scan.cp;
            o_is_substituted <= scan.sub;
            o_source_bytes   <= scan.len;
            o_run_last       <= !scan.more;
            o_text_last      <= !scan.more && r_eot;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > 3'd4)
    `ASSERT_CLK(a_accept_has_room, i_clk, i_rst_n, accept |-> base <= 3'd3)
    `ASSERT_CLK(a_eot_resolves, i_clk, i_rst_n, (accept && i_end_of_text) |=> scan.busy)
    `ASSERT_CLK(a_sub_form, i_clk, i_rst_n,
        (o_out_valid && o_is_substituted) |->
        (o_source_bytes == 3'd1 && o_code_point == u8d_pkg::REPLACEMENT))
    `ASSERT_CLK(a_scalar_range, i_clk, i_rst_n,
        (o_out_valid && !o_is_substituted) |->
        (o_code_point <= u8d_pkg::MAX_CP &&
         (o_code_point < u8d_pkg::SURR_LO || o_code_point > u8d_pkg::SURR_HI)))
    `ASSERT_CLK(a_text_last_ends_run, i_clk, i_rst_n,
        (o_out_valid && o_text_last) |-> o_run_last)

endmodule
